// ----- src/npp_pkg.sv -----
// npp_pkg: shared types, constants and helper functions of the nearest path point block
// no dependencies

package npp_pkg;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam int unsigned        CORDIC_STEPS = 28;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] heading;
    logic [31:0] curvature;
  } npp_point_t;

  typedef struct packed {
    logic [31:0] proj_x;
    logic [31:0] proj_y;
    logic [31:0] proj_heading;
  } npp_proj_res_t;

  typedef struct packed {
    logic        path_empty;
    logic [9:0]  match_index;
    logic [31:0] match_x;
    logic [31:0] match_y;
    logic [31:0] match_heading;
    logic [31:0] proj_x;
    logic [31:0] proj_y;
    logic [31:0] proj_heading;
    logic [31:0] proj_curvature;
  } npp_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_PROJ_GO,
    ST_PROJ_WAIT,
    ST_EMIT
  } npp_state_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_CORDIC,
    PS_ROUND,
    PS_OFF_MUL,
    PS_OFF_SUM,
    PS_PROJ_MUL,
    PS_FINAL
  } npp_pstate_t;

  function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sd210828714;
      5'd1:    v = 34'sd124459457;
      5'd2:    v = 34'sd65760959;
      5'd3:    v = 34'sd33381290;
      5'd4:    v = 34'sd16755422;
      5'd5:    v = 34'sd8385879;
      5'd6:    v = 34'sd4193963;
      5'd7:    v = 34'sd2097109;
      5'd8:    v = 34'sd1048571;
      5'd9:    v = 34'sd524287;
      5'd10:   v = 34'sd262144;
      5'd11:   v = 34'sd131072;
      5'd12:   v = 34'sd65536;
      5'd13:   v = 34'sd32768;
      5'd14:   v = 34'sd16384;
      5'd15:   v = 34'sd8192;
      5'd16:   v = 34'sd4096;
      5'd17:   v = 34'sd2048;
      5'd18:   v = 34'sd1024;
      5'd19:   v = 34'sd512;
      5'd20:   v = 34'sd256;
      5'd21:   v = 34'sd128;
      5'd22:   v = 34'sd64;
      5'd23:   v = 34'sd32;
      5'd24:   v = 34'sd16;
      5'd25:   v = 34'sd8;
      5'd26:   v = 34'sd4;
      5'd27:   v = 34'sd2;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [71:0] v);
    logic [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/npp_in_if.sv -----
// npp_in_if: input channel carrying load and query items
// no dependencies

interface npp_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  point_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] point_heading;
  logic [31:0] point_curvature;

  modport source (output valid, req_type, point_index, pos_x, pos_y, point_heading,
                  point_curvature, input ready);
  modport sink (input valid, req_type, point_index, pos_x, pos_y, point_heading,
                point_curvature, output ready);
endinterface

// ----- src/npp_out_if.sv -----
// npp_out_if: result channel of the projection block
// no dependencies

interface npp_out_if;
  logic        valid;
  logic        ready;
  logic        path_empty;
  logic [9:0]  match_index;
  logic [31:0] match_x;
  logic [31:0] match_y;
  logic [31:0] match_heading;
  logic [31:0] proj_x;
  logic [31:0] proj_y;
  logic [31:0] proj_heading;
  logic [31:0] proj_curvature;

  modport source (output valid, path_empty, match_index, match_x, match_y, match_heading,
                  proj_x, proj_y, proj_heading, proj_curvature, input ready);
  modport sink (input valid, path_empty, match_index, match_x, match_y, match_heading,
                proj_x, proj_y, proj_heading, proj_curvature, output ready);
endinterface

// ----- src/nearest_path_point_projection.sv -----
// nearest_path_point_projection: top level, point store, sequencer and result register
// depends on npp_pkg, npp_in_if, npp_out_if, npp_ram, npp_search, npp_proj
//
// channel | direction | carries
// in_ch   | sink      | load of one path point or query of a vehicle position
// out_ch  | source    | one projection result per query
// cfg     | write     | path_length
//
// a load is written into the store on its transfer; a query result becomes valid after the walk and the projection
// the walk reads up to path_length points (at most MAX_POINTS), ending about 30 points after the last improvement
// the walk reads one point a cycle from the store's read port, then a 28-step cordic runs
// in_ch.ready is high only between queries; loads flow one per cycle
// a finished result waits in the output register while loads go on
// reset is synchronous and active low; it clears path_length, the store is not cleared

module nearest_path_point_projection import npp_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int STALL_WINDOW = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  npp_in_if.sink       in_ch,
  npp_out_if.source    out_ch
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(MAX_POINTS + 1);

  npp_state_t         state_r, state_nxt;
  logic [10:0]        path_length_r;
  logic [LW-1:0]      len_eff;
  logic               in_xfer, out_load;
  logic signed [31:0] px_r, py_r;
  npp_point_t         m_r, rdata, wdata;
  logic [AW-1:0]      best_r, best_idx, srch_addr;
  npp_proj_res_t      pres, pres_r;
  npp_result_t        out_r, out_nxt;
  logic               out_valid_r, empty_r;
  logic               we, re, srch_re, srch_done, srch_start, proj_start, proj_done;
  logic [AW-1:0]      raddr;

  assign len_eff = (32'(path_length_r) > MAX_POINTS) ? LW'(MAX_POINTS) : LW'(path_length_r);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign we    = in_xfer && (in_ch.req_type == REQ_LOAD) && (32'(in_ch.point_index) < MAX_POINTS);
  assign wdata = '{x: in_ch.pos_x, y: in_ch.pos_y, heading: in_ch.point_heading,
                   curvature: in_ch.point_curvature};
  assign re    = srch_re || (state_r == ST_FETCH);
  assign raddr = (state_r == ST_FETCH) ? best_r : srch_addr;

  npp_ram #(.WIDTH($bits(npp_point_t)), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(in_ch.point_index)),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  npp_search #(.MAX_POINTS(MAX_POINTS), .STALL_WINDOW(STALL_WINDOW)) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (srch_start),
    .len      (len_eff),
    .px       (px_r),
    .py       (py_r),
    .rd_data  (rdata),
    .rd_en    (srch_re),
    .rd_addr  (srch_addr),
    .done     (srch_done),
    .best_idx (best_idx)
  );

  npp_proj u_proj (
    .clk   (clk),
    .rst_n (rst_n),
    .start (proj_start),
    .px    (px_r),
    .py    (py_r),
    .mpt   (m_r),
    .done  (proj_done),
    .res   (pres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      path_length_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        path_length_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    srch_start = 1'b0;
    proj_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_ch.req_type == REQ_QUERY) begin
          if (len_eff == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            srch_start = 1'b1;
            state_nxt  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH:      state_nxt = ST_FETCH_WAIT;
      ST_FETCH_WAIT: state_nxt = ST_PROJ_GO;
      ST_PROJ_GO: begin
        proj_start = 1'b1;
        state_nxt  = ST_PROJ_WAIT;
      end
      ST_PROJ_WAIT: begin
        if (proj_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (empty_r) begin
      out_nxt            = '0;
      out_nxt.path_empty = 1'b1;
    end else begin
      out_nxt.path_empty     = 1'b0;
      out_nxt.match_index    = 10'(best_r);
      out_nxt.match_x        = m_r.x;
      out_nxt.match_y        = m_r.y;
      out_nxt.match_heading  = m_r.heading;
      out_nxt.proj_x         = pres_r.proj_x;
      out_nxt.proj_y         = pres_r.proj_y;
      out_nxt.proj_heading   = pres_r.proj_heading;
      out_nxt.proj_curvature = m_r.curvature;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px_r    <= $signed(in_ch.pos_x);
      py_r    <= $signed(in_ch.pos_y);
      empty_r <= (len_eff == '0);
    end
    if (srch_done) begin
      best_r <= best_idx;
    end
    if (state_r == ST_FETCH_WAIT) begin
      m_r <= rdata;
    end
    if (proj_done) begin
      pres_r <= pres;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.path_empty     = out_r.path_empty;
  assign out_ch.match_index    = out_r.match_index;
  assign out_ch.match_x        = out_r.match_x;
  assign out_ch.match_y        = out_r.match_y;
  assign out_ch.match_heading  = out_r.match_heading;
  assign out_ch.proj_x         = out_r.proj_x;
  assign out_ch.proj_y         = out_r.proj_y;
  assign out_ch.proj_heading   = out_r.proj_heading;
  assign out_ch.proj_curvature = out_r.proj_curvature;

endmodule

// ----- src/npp_ram.sv -----
// npp_ram: generic simple dual port RAM, one write and one registered read port
// no dependencies

module npp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/npp_search.sv -----
// npp_search: walks the point store one entry a cycle and keeps the nearest point
// depends on npp_pkg; reads the store through the top level's RAM read port

module npp_search import npp_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int STALL_WINDOW = 30
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [$clog2(MAX_POINTS+1)-1:0] len,
  input  logic signed [31:0]              px,
  input  logic signed [31:0]              py,
  input  npp_point_t                      rd_data,
  output logic                            rd_en,
  output logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
  output logic                            done,
  output logic [$clog2(MAX_POINTS)-1:0]   best_idx
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(MAX_POINTS + 1);
  localparam int SW = $clog2(STALL_WINDOW + 2);

  logic              active_r, issuing_r, stop_r, have_r;
  logic [LW-1:0]     issue_idx_r;
  logic [LW-1:0]     issue_next;
  logic              v1_r, v2_r, v3_r;
  logic [AW-1:0]     idx1_r, idx2_r, idx3_r;
  logic [31:0]       ax_r, ay_r;
  logic [63:0]       a2_r, b2_r;
  logic [64:0]       best_d_r;
  logic [AW-1:0]     best_r;
  logic [SW-1:0]     stall_r;
  logic [SW-1:0]     stall_nxt;
  logic signed [32:0] dx, dy;
  logic [64:0]       dist_sq;
  logic              better, cmp_en;

  assign issue_next = issue_idx_r + LW'(1);
  assign rd_en      = issuing_r;
  assign rd_addr    = issue_idx_r[AW-1:0];
  assign best_idx   = best_r;
  assign done       = active_r && !issuing_r && !v1_r && !v2_r && !v3_r;

  assign dx     = 33'($signed(rd_data.x)) - 33'(px);
  assign dy     = 33'($signed(rd_data.y)) - 33'(py);
  assign dist_sq = 65'(a2_r) + 65'(b2_r);
  assign cmp_en = v3_r && !stop_r;
  assign better = !have_r || (dist_sq < best_d_r);
  assign stall_nxt = better ? SW'(1) : stall_r + SW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      issuing_r <= 1'b0;
      stop_r    <= 1'b0;
      have_r    <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      stall_r   <= '0;
      issue_idx_r <= '0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (start) begin
        active_r    <= 1'b1;
        issuing_r   <= 1'b1;
        stop_r      <= 1'b0;
        have_r      <= 1'b0;
        stall_r     <= '0;
        issue_idx_r <= '0;
      end else begin
        if (done) begin
          active_r <= 1'b0;
        end
        if (issuing_r) begin
          issue_idx_r <= issue_next;
          if (issue_next == len) begin
            issuing_r <= 1'b0;
          end
        end
        if (cmp_en) begin
          have_r  <= 1'b1;
          stall_r <= stall_nxt;
          if (32'(stall_nxt) > STALL_WINDOW) begin
            stop_r    <= 1'b1;
            issuing_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= rd_addr;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    ax_r   <= dx[32] ? 32'(-dx) : dx[31:0];
    ay_r   <= dy[32] ? 32'(-dy) : dy[31:0];
    a2_r   <= 64'(ax_r) * 64'(ax_r);
    b2_r   <= 64'(ay_r) * 64'(ay_r);
    if (cmp_en && better) begin
      best_d_r <= dist_sq;
      best_r   <= idx3_r;
    end
  end

endmodule

// ----- src/npp_proj.sv -----
// npp_proj: cordic sine and cosine of the match heading and tangent projection
// depends on npp_pkg

module npp_proj import npp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  npp_point_t         mpt,
  output logic               done,
  output npp_proj_res_t      res
);

  npp_pstate_t        state_r, state_nxt;
  logic [4:0]         it_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [31:0] c_r, s_r;
  logic signed [65:0] pdx_r, pdy_r;
  logic signed [37:0] off_r;
  logic signed [69:0] qx_r, qy_r, kh_r;

  logic signed [33:0] a0, a1, a2, xs, ys, atn;
  logic               flip0;
  logic signed [33:0] cr, sr;
  logic signed [66:0] sum67;
  logic signed [71:0] pxs, pys, phs;

  always_comb begin
    a0 = 34'($signed(mpt.heading));
    if (a0 > PI_Q28) begin
      a1 = a0 - TWO_PI_Q28;
    end else if (a0 < -PI_Q28) begin
      a1 = a0 + TWO_PI_Q28;
    end else begin
      a1 = a0;
    end
    flip0 = 1'b1;
    if (a1 > HALF_PI_Q28) begin
      a2 = a1 - PI_Q28;
    end else if (a1 < -HALF_PI_Q28) begin
      a2 = a1 + PI_Q28;
    end else begin
      a2 = a1;
      flip0 = 1'b0;
    end
  end

  assign xs  = x_r >>> it_r;
  assign ys  = y_r >>> it_r;
  assign atn = atan_q28(it_r);
  assign cr  = (x_r + 34'sd2) >>> 2;
  assign sr  = (y_r + 34'sd2) >>> 2;
  assign sum67 = 67'(pdx_r) + 67'(pdy_r) + (67'sd1 <<< 27);

  assign pxs = 72'($signed(mpt.x)) + 72'((qx_r + (70'sd1 <<< 27)) >>> 28);
  assign pys = 72'($signed(mpt.y)) + 72'((qy_r + (70'sd1 <<< 27)) >>> 28);
  assign phs = 72'($signed(mpt.heading)) + 72'((kh_r + 70'sd2048) >>> 12);

  assign res.proj_x       = sat32(pxs);
  assign res.proj_y       = sat32(pys);
  assign res.proj_heading = sat32(phs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done      = 1'b0;
    case (state_r)
      PS_IDLE: begin
        if (start) begin
          state_nxt = PS_CORDIC;
        end
      end
      PS_CORDIC: begin
        if (32'(it_r) == CORDIC_STEPS - 1) begin
          state_nxt = PS_ROUND;
        end
      end
      PS_ROUND:    state_nxt = PS_OFF_MUL;
      PS_OFF_MUL:  state_nxt = PS_OFF_SUM;
      PS_OFF_SUM:  state_nxt = PS_PROJ_MUL;
      PS_PROJ_MUL: state_nxt = PS_FINAL;
      PS_FINAL: begin
        done      = 1'b1;
        state_nxt = PS_IDLE;
      end
      default: state_nxt = PS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      PS_IDLE: begin
        x_r    <= GAIN_Q30;
        y_r    <= '0;
        z_r    <= a2;
        flip_r <= flip0;
        it_r   <= '0;
        dx_r   <= 33'(px) - 33'($signed(mpt.x));
        dy_r   <= 33'(py) - 33'($signed(mpt.y));
      end
      PS_CORDIC: begin
        if (!z_r[33]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atn;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atn;
        end
        it_r <= it_r + 5'd1;
      end
      PS_ROUND: begin
        c_r <= flip_r ? 32'(-cr) : 32'(cr);
        s_r <= flip_r ? 32'(-sr) : 32'(sr);
      end
      PS_OFF_MUL: begin
        pdx_r <= 66'(dx_r) * 66'(c_r);
        pdy_r <= 66'(dy_r) * 66'(s_r);
      end
      PS_OFF_SUM: begin
        off_r <= 38'(sum67 >>> 28);
      end
      PS_PROJ_MUL: begin
        qx_r <= 70'(off_r) * 70'(c_r);
        qy_r <= 70'(off_r) * 70'(s_r);
        kh_r <= 70'(off_r) * 70'($signed(mpt.curvature));
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/npp_checker.sv -----
// npp_checker: port-level checks of the nearest path point block, bound to the top level
// depends on nearest_path_point_projection

module npp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_path_empty,
  input logic [9:0]  out_match_index,
  input logic [31:0] out_proj_x,
  input logic [31:0] out_proj_heading
);

  // a query transfer closes the input until the result is built
  a_query_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type |=> !in_ready)
    else $error("input still open after query transfer");

  // empty-path results carry zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_empty |-> out_match_index == 10'd0 && out_proj_x == 32'd0 &&
    out_proj_heading == 32'd0)
    else $error("empty-path result with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_match_index) && $stable(out_proj_x))
    else $error("result changed while stalled");

endmodule

bind nearest_path_point_projection npp_checker u_npp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_req_type      (in_ch.req_type),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_path_empty   (out_ch.path_empty),
  .out_match_index  (out_ch.match_index),
  .out_proj_x       (out_ch.proj_x),
  .out_proj_heading (out_ch.proj_heading)
);
